@@ hw/rtl/svs_pkg.sv @@
`timescale 1ns / 1ps

package svs_pkg;

    // counter and duty widths
    localparam int TIMER_WIDTH = 24;
    localparam int DUTY_WIDTH  = 8;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [DUTY_WIDTH-1:0]  FULL_DUTY_RESET = {DUTY_WIDTH{1'b1}};

    // configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 24;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VALVE_TYPE     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRE_DELAY     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FULL_DUTY_TIME = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_DUTY      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FULL_DUTY      = 3'd4;

    // input command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // valve type codes
    localparam logic VALVE_NC = 1'b0;

    // valve states
    typedef enum logic [2:0] {
        ST_CLOSED    = 3'd0,
        ST_OPEN      = 3'd1,
        ST_FIRE      = 3'd2,
        ST_OPEN_CMD  = 3'd3,
        ST_CLOSE_CMD = 3'd4,
        ST_OPENING   = 3'd5,
        ST_CLOSING   = 3'd6
    } valve_state_t;

endpackage

@@ hw/rtl/solenoid_valve_sequencer.sv @@
`timescale 1ns / 1ps

// Solenoid valve sequencer. Each transfer on the s_ side is a tick, a direct
// state write or an elapsed-timer clear (s_tuser), and each one yields exactly
// one result on the m_ side with the valve state, the PWM duty now driven and
// a flag that is set when that item rewrote the duty. The block takes one item
// every clock cycle while no result is held back by m_tready; an item sits in
// the input register after the edge that accepts it, and the state update loads
// its result into the result register, raising m_tvalid, once that register is
// empty or being taken. The output register lets the next item enter while a
// result waits. Registers must be written through the cfg_ port only while no
// item is in flight (not enforced); indexes past the last register are ignored.
module solenoid_valve_sequencer
    import svs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [2:0] new_state, rest zero
    input  logic [1:0]                 s_tuser,   // [1:0] command
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata    // [2:0] valve_state,
                                                  // [10:3] pwm_duty,
                                                  // [11] duty_written, rest zero
);

    // configuration registers
    logic                   valve_type_reg;
    logic [TIMER_WIDTH-1:0] fire_delay_reg;
    logic [TIMER_WIDTH-1:0] full_duty_time_reg;
    logic [DUTY_WIDTH-1:0]  hold_duty_reg;
    logic [DUTY_WIDTH-1:0]  full_duty_reg;

    // sequencer state
    valve_state_t           state_reg, state_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [DUTY_WIDTH-1:0]  drive_reg, drive_next;
    logic                   wrote_next;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [2:0] in_nstate_reg;

    // result register
    logic                  out_valid_reg;
    valve_state_t          out_state_reg;
    logic [DUTY_WIDTH-1:0] out_duty_reg;
    logic                  out_wrote_reg;

    logic                   advance;
    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic                   is_nc;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_wrote_reg, out_duty_reg, out_state_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valve_type_reg     <= VALVE_NC;
            fire_delay_reg     <= '0;
            full_duty_time_reg <= '0;
            hold_duty_reg      <= '0;
            full_duty_reg      <= FULL_DUTY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_VALVE_TYPE:     valve_type_reg     <= cfg_data[0];
                REG_FIRE_DELAY:     fire_delay_reg     <= cfg_data[TIMER_WIDTH-1:0];
                REG_FULL_DUTY_TIME: full_duty_time_reg <= cfg_data[TIMER_WIDTH-1:0];
                REG_HOLD_DUTY:      hold_duty_reg      <= cfg_data[DUTY_WIDTH-1:0];
                REG_FULL_DUTY:      full_duty_reg      <= cfg_data[DUTY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // saturating tick count
    assign elapsed_inc = (elapsed_reg != TIMER_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign is_nc       = (valve_type_reg == VALVE_NC);

    // state rule for the item in the input register
    always_comb begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        drive_next   = drive_reg;
        wrote_next   = 1'b0;
        unique case (in_cmd_reg)
            CMD_TICK: begin
                elapsed_next = elapsed_inc;
                unique case (state_reg)
                    ST_FIRE: begin
                        if (elapsed_inc >= fire_delay_reg) begin
                            state_next   = is_nc ? ST_OPEN_CMD : ST_CLOSE_CMD;
                            elapsed_next = '0;
                        end
                    end
                    ST_OPEN_CMD: begin
                        drive_next   = is_nc ? full_duty_reg : '0;
                        wrote_next   = 1'b1;
                        state_next   = is_nc ? ST_OPENING : ST_OPEN;
                        elapsed_next = '0;
                    end
                    ST_CLOSE_CMD: begin
                        drive_next   = is_nc ? '0 : full_duty_reg;
                        wrote_next   = 1'b1;
                        state_next   = is_nc ? ST_CLOSED : ST_CLOSING;
                        elapsed_next = '0;
                    end
                    ST_OPENING, ST_CLOSING: begin
                        if (elapsed_inc >= full_duty_time_reg) begin
                            drive_next   = hold_duty_reg;
                            wrote_next   = 1'b1;
                            state_next   = (state_reg == ST_OPENING) ? ST_OPEN : ST_CLOSED;
                            elapsed_next = '0;
                        end
                    end
                    ST_CLOSED: begin
                        if (is_nc) begin
                            drive_next = '0;
                            wrote_next = 1'b1;
                        end
                    end
                    ST_OPEN: ;
                    default: ;
                endcase
            end
            CMD_SET: begin
                // the unused state code leaves the state alone
                if (in_nstate_reg <= 3'(ST_CLOSING)) begin
                    state_next = valve_state_t'(in_nstate_reg);
                end
            end
            CMD_CLEAR: begin
                elapsed_next = '0;
            end
            default: ;
        endcase
    end

    // input register and sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_CLOSED;
            elapsed_reg  <= '0;
            drive_reg    <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg   <= state_next;
                elapsed_reg <= elapsed_next;
                drive_reg   <= drive_next;
            end
        end
    end

    // input payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg    <= s_tuser;
            in_nstate_reg <= s_tdata[2:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg <= state_next;
            out_duty_reg  <= drive_next;
            out_wrote_reg <= wrote_next;
        end
    end

endmodule

@@ hw/rtl/svs_checker.sv @@
`timescale 1ns / 1ps

module svs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a waiting result is held unchanged
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // the unused state code never shows up in a result
    a_state_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("result carries unused state code");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:12] == 4'd0)
        else $error("result padding not zero");

    // with no result waiting the input side is always open
    a_ready_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with no result waiting");

endmodule

bind solenoid_valve_sequencer svs_checker u_svs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
